### hw/rtl/bcld_pkg.sv
// ----------------------------------------------------------------------------
// bcld_pkg
// Types and constants shared by the button click, long-press and
// double-click detector.
// ----------------------------------------------------------------------------
package bcld_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned FIELD_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_HIGH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_NUMBER = 3'd4;

	localparam logic [FIELD_W-1:0] DEF_LONG_PRESS    = 16'd500;
	localparam logic [FIELD_W-1:0] DEF_DOUBLE_WINDOW = 16'd150;
	localparam logic [FIELD_W-1:0] DEF_TICK_PERIOD   = 16'd10;
	localparam logic [FIELD_W-1:0] DEF_BUTTON_NUMBER = 16'd0;
	localparam int unsigned        MIN_DOUBLE_GAP    = 30;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_PRESSED  = 2'd1,
		MODE_WAIT     = 2'd2,
		MODE_RELEASED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_CLICK  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		CHG_NONE = 2'd0,
		CHG_FALL = 2'd1,
		CHG_RISE = 2'd2
	} lvl_chg_t;

	typedef struct packed {
		logic               idle_high;
		logic [FIELD_W-1:0] long_press_time;
		logic [FIELD_W-1:0] double_window;
		logic [FIELD_W-1:0] tick_period;
		logic [FIELD_W-1:0] button_number;
	} cfg_t;

endpackage

### hw/rtl/bcld_rules.sv
// ----------------------------------------------------------------------------
// bcld_rules
// Evaluates the ordered press/release rules for one sample and gives
// the next state and the event to report.
// ----------------------------------------------------------------------------
module bcld_rules import bcld_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  cfg_t                   cfg,
	input  logic                   raw_level,
	input  mode_t                  mode,
	input  logic                   last_level,
	input  logic [TIMER_WIDTH-1:0] hold_time,
	input  logic [TIMER_WIDTH-1:0] gap_time,
	output mode_t                  mode_nxt,
	output logic                   level_nxt,
	output logic [TIMER_WIDTH-1:0] hold_nxt,
	output logic [TIMER_WIDTH-1:0] gap_nxt,
	output event_t                 ev
);

	localparam int unsigned CMP_W = (TIMER_WIDTH > FIELD_W) ? TIMER_WIDTH : FIELD_W;
	localparam int unsigned SUM_W = CMP_W + 1;

	function automatic logic [TIMER_WIDTH-1:0] sat_add(
		input logic [TIMER_WIDTH-1:0] t,
		input logic [FIELD_W-1:0]     inc
	);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] cap;
		begin
			cap = {{(SUM_W-TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};
			sum = SUM_W'(t) + SUM_W'(inc);
			sat_add = (sum > cap) ? {TIMER_WIDTH{1'b1}} : sum[TIMER_WIDTH-1:0];
		end
	endfunction

	logic                   level;
	lvl_chg_t               chg;
	mode_t                  m0, m1, m3, m4;
	logic [TIMER_WIDTH-1:0] hold_a, gap_a;
	logic                   long_hit, win_end, click_hit, dbl_hit;

	assign level = cfg.idle_high ? raw_level : ~raw_level;

	always_comb begin
		if (level == last_level) begin
			chg = CHG_NONE;
		end else if (last_level) begin
			chg = CHG_FALL;
		end else begin
			chg = CHG_RISE;
		end
	end

	// Each rule sees the mode left by the rules before it.
	assign m0       = (mode == MODE_IDLE && chg == CHG_FALL) ? MODE_PRESSED : mode;
	assign m1       = (m0 == MODE_PRESSED && chg == CHG_RISE) ? MODE_WAIT : m0;
	assign hold_a   = (m1 == MODE_PRESSED && chg == CHG_NONE) ?
	                  sat_add(hold_time, cfg.tick_period) : hold_time;
	assign long_hit = (m1 == MODE_PRESSED) &&
	                  (CMP_W'(hold_a) >= CMP_W'(cfg.long_press_time));
	assign m3       = long_hit ? MODE_IDLE : m1;
	assign gap_a    = (m3 == MODE_WAIT) ? sat_add(gap_time, cfg.tick_period) : gap_time;
	assign win_end  = (m3 == MODE_WAIT) &&
	                  (CMP_W'(gap_a) >= CMP_W'(cfg.double_window));
	assign m4       = win_end ? MODE_RELEASED : m3;
	assign click_hit = (m4 == MODE_RELEASED);
	assign dbl_hit  = (m4 == MODE_WAIT) && (chg == CHG_FALL) &&
	                  (CMP_W'(gap_a) >= CMP_W'(MIN_DOUBLE_GAP));

	always_comb begin
		level_nxt = level;
		if (dbl_hit || click_hit || long_hit) begin
			mode_nxt = MODE_IDLE;
			hold_nxt = '0;
			gap_nxt  = '0;
		end else begin
			mode_nxt = m4;
			hold_nxt = hold_a;
			gap_nxt  = gap_a;
		end
	end

	always_comb begin
		priority if (dbl_hit) begin
			ev = EV_DOUBLE;
		end else if (click_hit) begin
			ev = EV_CLICK;
		end else if (long_hit) begin
			ev = EV_LONG;
		end else begin
			ev = EV_NONE;
		end
	end

endmodule

### hw/rtl/button_click_long_double_detector.sv
// ----------------------------------------------------------------------------
// button_click_long_double_detector
// Turns a stream of sampled button levels into click, long-press and
// double-click events.
// ----------------------------------------------------------------------------
// The slave stream carries one sampled pin level per request; the master
// stream returns exactly one result per request, in order, with the event
// code and the configured button number (zero when there is no event).
// The user must write registers through cfg_wen, cfg_addr and cfg_wdata only
// while the stream is idle; the block itself does not enforce this. Writes to unused indexes are ignored.
// A request is held in the input register, then the rule logic updates
// the detector state and loads the output register, from which the result is
// offered. One request is accepted every cycle while the receiver does not
// stall; the single output register decides the rate.
// When the receiver stalls, the result holds in the output register, and once
// the input register holds the next request, s_tready falls.
// Reset clears the pipeline, returns the detector to idle with a released
// level and zero timers, and loads the default register values.
// ----------------------------------------------------------------------------
module button_click_long_double_detector import bcld_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [0] raw_level, [7:1] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata   // [1:0] event_res, [17:2] event_button
);

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic                   raw_s1;
	mode_t                  mode_q;
	logic                   last_level_q;
	logic [TIMER_WIDTH-1:0] hold_q, gap_q;
	logic                   out_valid_q;
	event_t                 out_res_q;
	logic [FIELD_W-1:0]     out_button_q;

	mode_t                  mode_nxt;
	logic                   level_nxt;
	logic [TIMER_WIDTH-1:0] hold_nxt, gap_nxt;
	event_t                 ev;
	logic                   adv;

	assign adv      = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_button_q, out_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_high       <= 1'b1;
			cfg_q.long_press_time <= DEF_LONG_PRESS;
			cfg_q.double_window   <= DEF_DOUBLE_WINDOW;
			cfg_q.tick_period     <= DEF_TICK_PERIOD;
			cfg_q.button_number   <= DEF_BUTTON_NUMBER;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_IDLE_HIGH:     cfg_q.idle_high       <= cfg_wdata[0];
				REG_LONG_PRESS:    cfg_q.long_press_time <= cfg_wdata;
				REG_DOUBLE_WINDOW: cfg_q.double_window   <= cfg_wdata;
				REG_TICK_PERIOD:   cfg_q.tick_period     <= cfg_wdata;
				REG_BUTTON_NUMBER: cfg_q.button_number   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata[0];
		end
	end

	bcld_rules #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_rules (
		.cfg        (cfg_q),
		.raw_level  (raw_s1),
		.mode       (mode_q),
		.last_level (last_level_q),
		.hold_time  (hold_q),
		.gap_time   (gap_q),
		.mode_nxt   (mode_nxt),
		.level_nxt  (level_nxt),
		.hold_nxt   (hold_nxt),
		.gap_nxt    (gap_nxt),
		.ev         (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			last_level_q <= 1'b1;
			hold_q       <= '0;
			gap_q        <= '0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				mode_q       <= mode_nxt;
				last_level_q <= level_nxt;
				hold_q       <= hold_nxt;
				gap_q        <= gap_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_res_q    <= ev;
			out_button_q <= (ev != EV_NONE) ? cfg_q.button_number : '0;
		end
	end

endmodule

### hw/rtl/bcld_checker.sv
// ----------------------------------------------------------------------------
// bcld_checker
// Port-level checks for the button event detector, bound to its top level.
// ----------------------------------------------------------------------------
module bcld_checker import bcld_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// The button number is only reported together with an event.
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == EV_NONE) |-> (m_tdata[17:2] == 16'd0))
		else $error("button number shown without an event");

	// A result that appears on an empty output matches an earlier accepted request.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching request");

endmodule

bind button_click_long_double_detector bcld_checker u_bcld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
